// ----- design/qtua_pkg.sv -----
`timescale 1ns / 1ps

package qtua_pkg;

  // Request kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 1'b1;

  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_DATA_W-1:0] LEARN_RATE_RST = 9'd205;
  localparam logic [CFG_DATA_W-1:0] DISCOUNT_RST   = 9'd128;

  typedef struct packed {
    logic [1:0]          kind;
    logic [3:0]          state_index;
    logic [3:0]          next_state_index;
    logic [1:0]          action_index;
    logic signed [15:0]  reward_value;
    logic signed [15:0]  load_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          best_action;
    logic signed [15:0]  best_value;
    logic signed [15:0]  written_value;
    logic                index_error;
  } out_rsp_t;

endpackage

// ----- design/q_table_update_argmax_top.sv -----
`timescale 1ns / 1ps

// Q-value table with load, best-action query and Q-learning update.
// Input channel in_req_i / in_valid_i / in_stall_o carries one request; it is
// taken on a clock edge with valid high and stall low. Each request yields one
// response on out_rsp_o / out_valid_o / out_stall_i.
// Steps from acceptance until the response register loads:
//   load or any index error or unused kind: index check and, for a load, the write
//   query:  one table read per action, then compare
//   update: row scan, one shared multiplier used
//           twice for gamma and alpha, then saturate and write back
// One table memory and one multiplier: only one request is in flight, and
// in_stall_o is high while it is worked on. A new request is taken while the
// last response still waits in the output register; if it still waits when
// the next response is done, the core holds that one and the input stalls.
// Reset clears control state and loads learn_rate = 205, discount = 128.
// Table contents are undefined until written by a load.
// cfg_we_i writes register cfg_idx_i (0 learn_rate, 1 discount); write only
// while idle.
module q_table_update_argmax_top #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_ACTIONS = 3,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [qtua_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [qtua_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  qtua_pkg::in_req_t                    in_req_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  output qtua_pkg::out_rsp_t                   out_rsp_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i
);

  localparam int unsigned DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(NUM_ACTIONS);
  localparam int unsigned DW    = ((VALUE_BITS > 16) ? VALUE_BITS : 16) + 3;
  localparam int unsigned MW    = qtua_pkg::CFG_DATA_W + 1;
  localparam int unsigned PW    = DW + MW;

  localparam logic signed [PW-1:0] VMAX =
    {{(PW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] VMIN =
    {{(PW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_SCAN_END, ST_MUL_G, ST_DIFF, ST_MUL_S, ST_SUM, ST_DONE
  } state_e;

  function automatic logic [VALUE_BITS-1:0] sat_fn(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    begin
      if (v > VMAX) begin
        r = VMAX;
      end else if (v < VMIN) begin
        r = VMIN;
      end else begin
        r = v;
      end
      return r[VALUE_BITS-1:0];
    end
  endfunction

  function automatic logic [15:0] to16_fn(input logic signed [VALUE_BITS-1:0] v);
    logic signed [PW-1:0] ext;
    begin
      ext = PW'(v);
      return ext[15:0];
    end
  endfunction

  function automatic logic [AW-1:0] addr_fn(input logic [3:0] row, input logic [3:0] col);
    return AW'(32'(row) * NUM_ACTIONS + 32'(col));
  endfunction

  state_e                        state_q;
  qtua_pkg::in_req_t             req_q;
  qtua_pkg::out_rsp_t            res_q;
  qtua_pkg::out_rsp_t            out_q;
  logic                          out_valid_q;
  logic [qtua_pkg::CFG_DATA_W-1:0] learn_rate_q;
  logic [qtua_pkg::CFG_DATA_W-1:0] discount_q;
  logic [CW-1:0]                 col_q;
  logic [CW-1:0]                 cmp_col_q;
  logic                          cmp_vld_q;
  logic signed [VALUE_BITS-1:0]  best_v_q;
  logic [CW-1:0]                 best_a_q;
  logic signed [VALUE_BITS-1:0]  q_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [DW-1:0]          diff_q;

  logic signed [VALUE_BITS-1:0]  best_v_d;
  logic [CW-1:0]                 best_a_d;
  logic                          idx_err;
  logic [3:0]                    scan_row;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic                          wr_en;
  logic [VALUE_BITS-1:0]         wr_data;
  logic [VALUE_BITS-1:0]         rd_data;
  logic signed [VALUE_BITS-1:0]  rd_val;
  logic signed [MW-1:0]          mul_a;
  logic signed [DW-1:0]          mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [PW-1:0]          gq;
  logic signed [PW-1:0]          diff_full;
  logic signed [PW-1:0]          step_adj;
  logic signed [PW-1:0]          step_val;
  logic signed [PW-1:0]          sum_val;
  logic [VALUE_BITS-1:0]         load_sat;
  logic [VALUE_BITS-1:0]         new_val;

  qtua_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    rd_val   = signed'(rd_data);
    best_v_d = best_v_q;
    best_a_d = best_a_q;
    // strictly larger only, so ties keep the lower action
    if (cmp_vld_q && (rd_val > best_v_q)) begin
      best_v_d = rd_val;
      best_a_d = cmp_col_q;
    end

    idx_err = 1'b0;
    unique case (req_q.kind)
      qtua_pkg::KIND_LOAD: begin
        idx_err = (32'(req_q.state_index) >= NUM_STATES) ||
                  (32'(req_q.action_index) >= NUM_ACTIONS);
      end
      qtua_pkg::KIND_QUERY: begin
        idx_err = (32'(req_q.state_index) >= NUM_STATES);
      end
      qtua_pkg::KIND_UPDATE: begin
        idx_err = (32'(req_q.state_index) >= NUM_STATES) ||
                  (32'(req_q.next_state_index) >= NUM_STATES) ||
                  (32'(req_q.action_index) >= NUM_ACTIONS);
      end
      default: begin
        idx_err = 1'b0;
      end
    endcase

    scan_row = (req_q.kind == qtua_pkg::KIND_UPDATE) ? req_q.next_state_index
                                                     : req_q.state_index;
    wr_addr  = addr_fn(req_q.state_index, {2'b00, req_q.action_index});
    rd_addr  = (state_q == ST_SCAN) ? addr_fn(scan_row, 4'(col_q)) : wr_addr;

    // shared multiplier: gamma * maxQ, then alpha * diff
    if (state_q == ST_MUL_G) begin
      mul_a = signed'({1'b0, discount_q});
      mul_b = DW'(best_v_q);
    end else begin
      mul_a = signed'({1'b0, learn_rate_q});
      mul_b = diff_q;
    end
    mul_p = PW'(mul_a) * PW'(mul_b);

    gq        = prod_q >>> 8;  // nonnegative product, shift truncates
    diff_full = PW'(req_q.reward_value) + gq - PW'(q_q);
    step_adj  = prod_q + (prod_q[PW-1] ? PW'(255) : PW'(0));
    step_val  = step_adj >>> 8;
    sum_val   = PW'(q_q) + step_val;
    new_val   = sat_fn(sum_val);
    load_sat  = sat_fn(PW'(req_q.load_value));

    wr_en   = ((state_q == ST_EXEC) && (req_q.kind == qtua_pkg::KIND_LOAD) && !idx_err) ||
              (state_q == ST_SUM);
    wr_data = (state_q == ST_SUM) ? new_val : load_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      req_q        <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      learn_rate_q <= qtua_pkg::LEARN_RATE_RST;
      discount_q   <= qtua_pkg::DISCOUNT_RST;
      col_q        <= '0;
      cmp_col_q    <= '0;
      cmp_vld_q    <= 1'b0;
      best_v_q     <= '0;
      best_a_q     <= '0;
      q_q          <= '0;
      prod_q       <= '0;
      diff_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == qtua_pkg::CFG_LEARN_RATE) begin
          learn_rate_q <= cfg_data_i;
        end else if (cfg_idx_i == qtua_pkg::CFG_DISCOUNT) begin
          discount_q <= cfg_data_i;
        end
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      cmp_vld_q <= 1'b0;
      if (cmp_vld_q) begin
        best_v_q <= best_v_d;
        best_a_q <= best_a_d;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_req_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_q    <= '0;
          best_v_q <= '0;
          best_a_q <= '0;
          col_q    <= '0;
          if (idx_err) begin
            res_q.index_error <= 1'b1;
            state_q           <= ST_DONE;
          end else begin
            unique case (req_q.kind) inside
              qtua_pkg::KIND_LOAD: begin
                res_q.written_value <= to16_fn(load_sat);
                state_q             <= ST_DONE;
              end
              qtua_pkg::KIND_QUERY, qtua_pkg::KIND_UPDATE: begin
                state_q <= ST_SCAN;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= 1'b1;
          cmp_col_q <= col_q;
          col_q     <= col_q + 1'b1;
          if (col_q == CW'(NUM_ACTIONS - 1)) begin
            state_q <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          // last compare lands here; Q(s,a) read is issued in parallel
          if (req_q.kind == qtua_pkg::KIND_QUERY) begin
            res_q.best_action <= 2'(best_a_d);
            res_q.best_value  <= to16_fn(best_v_d);
            state_q           <= ST_DONE;
          end else begin
            state_q <= ST_MUL_G;
          end
        end
        ST_MUL_G: begin
          q_q     <= rd_val;
          prod_q  <= mul_p;
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_q  <= DW'(diff_full);
          state_q <= ST_MUL_S;
        end
        ST_MUL_S: begin
          prod_q  <= mul_p;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          res_q.written_value <= to16_fn(new_val);
          state_q             <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_rsp_o   = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/qtua_ram.sv -----
`timescale 1ns / 1ps

module qtua_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
